FILE: src/ooo_alu_pkg.sv
// ----------------------------------------------------------------------------
// ooo_alu_pkg
// Shared types, widths and latency table for the out-of-order ALU unit.
// ----------------------------------------------------------------------------
package ooo_alu_pkg;

    localparam int DATA_W = 64;
    localparam int HALF_W = 32;
    localparam int TAG_W  = 5;
    localparam int CD_W   = 3;
    localparam int OPC_W  = 3;
    localparam int TAG_CODES = 2 ** TAG_W;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [TAG_W-1:0]  tag_t;
    typedef logic [CD_W-1:0]   count_t;

    // beat kind carried on tuser
    typedef enum logic [1:0] {
        OP_ISSUE = 2'd0,
        OP_TICK  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_RSVD  = 2'd3
    } oper_t;

    // instruction opcodes; codes 5..7 behave like NOP
    typedef enum logic [OPC_W-1:0] {
        OPC_NOP = 3'd0,
        OPC_ADD = 3'd1,
        OPC_MUL = 3'd2,
        OPC_CMP = 3'd3,
        OPC_LDC = 3'd4
    } opc_t;

    // countdown loaded on issue, chosen by opcode
    function automatic count_t issue_count(input logic [OPC_W-1:0] opc);
        count_t cnt;
        unique case (opc)
            OPC_ADD: cnt = 3'd3;
            OPC_MUL: cnt = 3'd5;
            OPC_CMP: cnt = 3'd3;
            OPC_LDC: cnt = 3'd2;
            default: cnt = 3'd1;
        endcase
        return cnt;
    endfunction

endpackage

FILE: src/ooo_alu_mul.sv
// ----------------------------------------------------------------------------
// ooo_alu_mul
// Two-stage 64x64 multiplier keeping the low 64 bits, built from 32x32 parts.
// ----------------------------------------------------------------------------
module ooo_alu_mul
(
    input  logic                clk,
    input  ooo_alu_pkg::data_t  a,
    input  ooo_alu_pkg::data_t  b,
    output ooo_alu_pkg::data_t  product
);

    logic [ooo_alu_pkg::DATA_W-1:0] p_ll_reg;
    logic [ooo_alu_pkg::HALF_W-1:0] p_lh_reg;
    logic [ooo_alu_pkg::HALF_W-1:0] p_hl_reg;
    logic [ooo_alu_pkg::HALF_W-1:0] cross_sum;
    ooo_alu_pkg::data_t             product_reg;
    logic [ooo_alu_pkg::DATA_W-1:0] p_lh_full;
    logic [ooo_alu_pkg::DATA_W-1:0] p_hl_full;
    logic [ooo_alu_pkg::DATA_W-1:0] a_lo;
    logic [ooo_alu_pkg::DATA_W-1:0] a_hi;
    logic [ooo_alu_pkg::DATA_W-1:0] b_lo;
    logic [ooo_alu_pkg::DATA_W-1:0] b_hi;

    // operand halves, zero-extended to the product width
    assign a_lo = {{ooo_alu_pkg::HALF_W{1'b0}}, a[ooo_alu_pkg::HALF_W-1:0]};
    assign a_hi = {{ooo_alu_pkg::HALF_W{1'b0}}, a[ooo_alu_pkg::DATA_W-1:ooo_alu_pkg::HALF_W]};
    assign b_lo = {{ooo_alu_pkg::HALF_W{1'b0}}, b[ooo_alu_pkg::HALF_W-1:0]};
    assign b_hi = {{ooo_alu_pkg::HALF_W{1'b0}}, b[ooo_alu_pkg::DATA_W-1:ooo_alu_pkg::HALF_W]};

    // stage 1: partial products; only the low half of the cross terms matters
    assign p_lh_full = a_lo * b_hi;
    assign p_hl_full = a_hi * b_lo;

    always_ff @(posedge clk)
    begin
        p_ll_reg <= a_lo * b_lo;
        p_lh_reg <= p_lh_full[ooo_alu_pkg::HALF_W-1:0];
        p_hl_reg <= p_hl_full[ooo_alu_pkg::HALF_W-1:0];
    end

    // stage 2: fold cross terms into the upper half
    assign cross_sum = p_lh_reg + p_hl_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= p_ll_reg + {cross_sum, {ooo_alu_pkg::HALF_W{1'b0}}};
    end

    assign product = product_reg;

endmodule

FILE: src/ooo_alu_exec.sv
// ----------------------------------------------------------------------------
// ooo_alu_exec
// Result selection for the held instruction: add, multiply, compare, load.
// ----------------------------------------------------------------------------
module ooo_alu_exec
(
    input  logic [ooo_alu_pkg::OPC_W-1:0] opcode,
    input  ooo_alu_pkg::data_t            first,
    input  ooo_alu_pkg::data_t            second,
    input  ooo_alu_pkg::data_t            product,
    input  ooo_alu_pkg::data_t            last_result,
    output ooo_alu_pkg::data_t            result
);

    logic signed [ooo_alu_pkg::DATA_W-1:0] sa;
    logic signed [ooo_alu_pkg::DATA_W-1:0] sb;
    ooo_alu_pkg::data_t                    cmp_val;

    assign sa = first;
    assign sb = second;

    // signed three-way compare
    always_comb
    begin
        priority if (sa == sb)
            cmp_val = '0;
        else if (sa > sb)
            cmp_val = ooo_alu_pkg::data_t'(1);
        else
            cmp_val = '1;
    end

    // NOP and unknown codes keep the previous result
    always_comb
    begin
        unique case (opcode)
            ooo_alu_pkg::OPC_ADD: result = first + second;
            ooo_alu_pkg::OPC_MUL: result = product;
            ooo_alu_pkg::OPC_CMP: result = cmp_val;
            ooo_alu_pkg::OPC_LDC: result = first;
            default:              result = last_result;
        endcase
    end

endmodule

FILE: src/ooo_alu_unit_with_rob_flush.sv
// ----------------------------------------------------------------------------
// ooo_alu_unit_with_rob_flush
// Single-entry ALU execution unit with reorder-buffer tag-range flush.
// ----------------------------------------------------------------------------
// Every accepted input beat (issue, tick or flush, chosen by s_axis_tuser)
// yields exactly one output beat in the next cycle, and a new beat is taken in
// every cycle as long as the output register is empty or being drained.
// The state update is a single pass of logic between the held-state registers
// and the output register. The 64-bit multiply runs in a two-stage 32x32
// pipeline fed from the held operands; it is always ready before the fifth
// tick that completes a multiply. Incoming tags are reduced modulo
// TAG_ENTRIES through a 32-entry constant table.
// ----------------------------------------------------------------------------
module ooo_alu_unit_with_rob_flush
#(
    parameter int TAG_ENTRIES = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] opcode, [66:3] first_operand, [130:67] second_operand,
    // [135:131] issue_tag, [140:136] flush_first, [145:141] flush_last
    input  logic [151:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] done_res, [64:1] result_value, [69:65] done_tag, [70] ready_res
    output logic [71:0]  m_axis_tdata
);

    // input fields
    logic [ooo_alu_pkg::OPC_W-1:0] opcode;
    ooo_alu_pkg::data_t            first_operand;
    ooo_alu_pkg::data_t            second_operand;
    ooo_alu_pkg::tag_t             issue_tag;
    ooo_alu_pkg::tag_t             flush_first;
    ooo_alu_pkg::tag_t             flush_last;
    ooo_alu_pkg::oper_t            operation;

    assign opcode         = s_axis_tdata[2:0];
    assign first_operand  = s_axis_tdata[66:3];
    assign second_operand = s_axis_tdata[130:67];
    assign issue_tag      = s_axis_tdata[135:131];
    assign flush_first    = s_axis_tdata[140:136];
    assign flush_last     = s_axis_tdata[145:141];
    assign operation      = ooo_alu_pkg::oper_t'(s_axis_tuser);

    // tag reduction table
    ooo_alu_pkg::tag_t tag_lut [ooo_alu_pkg::TAG_CODES];

    for (genvar gi = 0; gi < ooo_alu_pkg::TAG_CODES; gi++)
    begin : g_tag_lut
        localparam int RED = gi % TAG_ENTRIES;
        assign tag_lut[gi] = ooo_alu_pkg::tag_t'(RED);
    end

    // held state
    logic                          busy_reg, busy_next;
    ooo_alu_pkg::count_t           cd_reg, cd_next;
    logic [ooo_alu_pkg::OPC_W-1:0] opc_reg, opc_next;
    ooo_alu_pkg::data_t            first_reg, first_next;
    ooo_alu_pkg::data_t            second_reg, second_next;
    ooo_alu_pkg::tag_t             tag_reg, tag_next;
    logic                          finished_reg, finished_next;
    logic                          flushing_reg, flushing_next;
    ooo_alu_pkg::data_t            last_reg, last_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [71:0]                   out_data_reg;

    logic                          in_acc;
    ooo_alu_pkg::data_t            product;
    ooo_alu_pkg::data_t            exec_result;
    ooo_alu_pkg::count_t           cd_dec;
    ooo_alu_pkg::tag_t             fl_first;
    ooo_alu_pkg::tag_t             fl_last;
    logic                          flush_hit;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // multiplier and result selection
    ooo_alu_mul u_mul
    (
        .clk     (clk),
        .a       (first_reg),
        .b       (second_reg),
        .product (product)
    );

    ooo_alu_exec u_exec
    (
        .opcode      (opc_reg),
        .first       (first_reg),
        .second      (second_reg),
        .product     (product),
        .last_result (last_reg),
        .result      (exec_result)
    );

    // flush range check, wrapping when first > last
    assign fl_first = tag_lut[flush_first];
    assign fl_last  = tag_lut[flush_last];

    always_comb
    begin
        if (fl_first <= fl_last)
            flush_hit = (tag_reg >= fl_first) && (tag_reg <= fl_last);
        else
            flush_hit = (tag_reg <= fl_last) || (tag_reg >= fl_first);
    end

    assign cd_dec = (cd_reg != '0) ? cd_reg - 1'b1 : cd_reg;

    // next state
    always_comb
    begin
        busy_next     = busy_reg;
        cd_next       = cd_reg;
        opc_next      = opc_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        tag_next      = tag_reg;
        finished_next = finished_reg;
        flushing_next = flushing_reg;
        last_next     = last_reg;
        if (in_acc)
        begin
            unique case (operation)
                ooo_alu_pkg::OP_ISSUE:
                begin
                    opc_next    = opcode;
                    first_next  = first_operand;
                    second_next = second_operand;
                    tag_next    = tag_lut[issue_tag];
                    busy_next   = 1'b1;
                    cd_next     = ooo_alu_pkg::issue_count(opcode);
                end
                ooo_alu_pkg::OP_TICK:
                begin
                    cd_next       = cd_dec;
                    finished_next = 1'b0;
                    flushing_next = 1'b0;
                    if (busy_reg && cd_dec == '0)
                    begin
                        last_next     = exec_result;
                        busy_next     = 1'b0;
                        finished_next = 1'b1;
                    end
                end
                ooo_alu_pkg::OP_FLUSH:
                begin
                    if (busy_reg && flush_hit)
                    begin
                        busy_next     = 1'b0;
                        flushing_next = 1'b1;
                        cd_next       = '0;
                    end
                end
                default:
                begin
                    busy_next = busy_reg;
                end
            endcase
        end
    end

    // output beat valid tracking
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_acc)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cd_reg        <= '0;
            opc_reg       <= ooo_alu_pkg::OPC_NOP;
            first_reg     <= '0;
            second_reg    <= '0;
            tag_reg       <= '0;
            finished_reg  <= 1'b0;
            flushing_reg  <= 1'b0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cd_reg        <= cd_next;
            opc_reg       <= opc_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            tag_reg       <= tag_next;
            finished_reg  <= finished_next;
            flushing_reg  <= flushing_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, built from the post-update state
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_data_reg <= {1'b0,
                             !flushing_next && (!busy_next || finished_next),
                             tag_next,
                             last_next,
                             finished_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // a running countdown always belongs to a busy unit
    a_cd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cd_reg != '0) |-> busy_reg)
        else $error("countdown running while unit idle");

    // busy only drops through completion or flush
    a_busy_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> (finished_reg || flushing_reg))
        else $error("busy cleared without completion or flush");

    // a tick always clears the flushing mark
    a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && operation == ooo_alu_pkg::OP_TICK) |=> !flushing_reg)
        else $error("flushing mark survived a tick");

endmodule
